// ===== rtl/core/mnsp_pkg.sv =====
// Package for the MML note sequence parser: parser state and result types,
// character and event codes, the tone table and the small arithmetic helpers.
// Depends on nothing; the parser top level imports it.
`default_nettype none

package mnsp_pkg;

    localparam int OCTAVE_ROWS = 7;
    localparam int ROW_LAST    = ((OCTAVE_ROWS < 7) ? OCTAVE_ROWS : 7) - 1;

    localparam logic [1:0] PK_NONE = 2'd0;
    localparam logic [1:0] PK_NOTE = 2'd1;
    localparam logic [1:0] PK_REST = 2'd2;

    localparam logic [1:0] EV_NOTE = 2'd0;
    localparam logic [1:0] EV_REST = 2'd1;
    localparam logic [1:0] EV_END  = 2'd2;

    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_SHARP  = "+";
    localparam logic [7:0] CH_FLAT   = "-";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_C      = "c";
    localparam logic [7:0] CH_D      = "d";
    localparam logic [7:0] CH_E      = "e";
    localparam logic [7:0] CH_F      = "f";
    localparam logic [7:0] CH_G      = "g";
    localparam logic [7:0] CH_A      = "a";
    localparam logic [7:0] CH_B      = "b";
    localparam logic [7:0] CH_REST   = "r";
    localparam logic [7:0] CH_TEMPO  = "t";
    localparam logic [7:0] CH_OCTAVE = "o";
    localparam logic [7:0] CH_LENGTH = "l";
    localparam logic [7:0] CH_UP     = ">";
    localparam logic [7:0] CH_DOWN   = "<";
    localparam logic [7:0] CH_SHIFT_UP   = "~";
    localparam logic [7:0] CH_SHIFT_DOWN = "_";

    localparam logic [3:0]        KEY_LAST   = 4'd11;
    localparam logic [3:0]        OCTAVE_TOP = 4'd15;
    localparam logic signed [3:0] OFFSET_MAX = 4'sd7;
    localparam logic signed [3:0] OFFSET_MIN = -4'sd8;
    localparam logic [9:0]        TEMPO_MAX  = 10'd999;

    typedef enum logic [2:0] {
        CM_IDLE,
        CM_TEMPO,
        CM_OCT_FIRST,
        CM_OCT_MORE,
        CM_LEN_FIRST,
        CM_LEN_SECOND
    } cmd_t;

    typedef struct packed {
        logic [1:0]        pk;
        logic [3:0]        key;
        logic              fpos;
        logic [3:0]        fd;
        logic [3:0]        sd;
        logic [1:0]        dc;
        logic              dot;
        logic [3:0]        bo;
        logic signed [3:0] oo;
        logic [6:0]        dl;
        logic [9:0]        tempo;
    } ps_t;

    localparam ps_t PS_RESET = '{
        pk: PK_NONE, key: 4'd0, fpos: 1'b0, fd: 4'd0, sd: 4'd0, dc: 2'd0,
        dot: 1'b0, bo: 4'd4, oo: 4'sd0, dl: 7'd4, tempo: 10'd120
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] hz;
        logic [6:0]  len;
        logic [9:0]  tempo;
        logic        last;
    } res_t;

    localparam logic [11:0] TONE_HZ [7][12] = '{
        '{12'd33,   12'd35,   12'd37,   12'd39,   12'd41,   12'd44,
          12'd46,   12'd49,   12'd52,   12'd55,   12'd58,   12'd62},
        '{12'd65,   12'd69,   12'd73,   12'd78,   12'd82,   12'd87,
          12'd93,   12'd98,   12'd104,  12'd110,  12'd117,  12'd123},
        '{12'd131,  12'd139,  12'd147,  12'd156,  12'd165,  12'd175,
          12'd185,  12'd196,  12'd208,  12'd220,  12'd233,  12'd247},
        '{12'd262,  12'd277,  12'd294,  12'd311,  12'd330,  12'd349,
          12'd370,  12'd392,  12'd415,  12'd440,  12'd466,  12'd494},
        '{12'd523,  12'd554,  12'd587,  12'd622,  12'd659,  12'd698,
          12'd740,  12'd784,  12'd831,  12'd880,  12'd932,  12'd988},
        '{12'd1047, 12'd1109, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
          12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976},
        '{12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
          12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951}
    };

    // Exact floor(x / 3) for every 8-bit x, by the reciprocal 171 / 512.
    function automatic logic [6:0] div3(input logic [7:0] x);
        logic [15:0] p;
        begin
            p = {8'd0, x} * 16'd171;
            return p[15:9];
        end
    endfunction

    function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
        begin
            return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
        end
    endfunction

    function automatic res_t build_event(input ps_t e);
        res_t              r;
        logic [6:0]        n;
        logic signed [5:0] row_s;
        logic [2:0]        row;
        logic [3:0]        key;
        begin
            unique case (e.dc)
                2'd0:    n = e.dl;
                2'd1:    n = {3'b000, e.fd};
                default: n = two_digits(e.fd, e.sd);
            endcase
            if (e.dot)
            begin
                n = div3({n, 1'b0});
            end
            row_s = $signed({2'b00, e.bo}) + $signed({{2{e.oo[3]}}, e.oo}) - 6'sd2 + 6'sd1;
            row_s = row_s - 6'sd0;
            if (row_s < 6'sd0)
            begin
                row = 3'd0;
            end
            else if (row_s > $signed(6'(ROW_LAST)))
            begin
                row = 3'(ROW_LAST);
            end
            else
            begin
                row = row_s[2:0];
            end
            key = (e.key > KEY_LAST) ? KEY_LAST : e.key;
            r.kind  = (e.pk == PK_NOTE) ? EV_NOTE : EV_REST;
            r.hz    = (e.pk == PK_NOTE) ? TONE_HZ[row][key] : 12'd0;
            r.len   = n;
            r.tempo = e.tempo;
            r.last  = 1'b0;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mml_note_sequence_parser.sv =====
// Top level of the MML note sequence parser: character decoding, parser state
// and a two-entry result buffer. Depends on mnsp_pkg.
`default_nettype none

// One character is taken per transaction and decoded combinationally into
// at most two events (note or rest, then end of score). The result buffer
// holds two entries, and a character is taken in the same cycle as the last
// waiting result leaves, so one character per cycle is sustained while each
// character yields at most one result and out_ready stays high. A character
// that yields two results holds in_ready low until the first result leaves.
module mml_note_sequence_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_char,
    input  logic        is_final,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [11:0] frequency_hz,
    output logic [6:0]  length_denominator,
    output logic [9:0]  tempo_bpm,
    output logic        run_end
);
    import mnsp_pkg::*;

    ps_t        st_reg, st_next;
    cmd_t       cm_reg, cm_next;
    res_t       slot0_reg, slot0_next, slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;

    logic       accept, pop;
    logic [7:0] dgt_full;
    logic [3:0] dgt;
    logic       is_num;
    res_t       r0, r1;
    logic [1:0] k;

    assign dgt_full = text_char - CH_ZERO;
    assign dgt      = dgt_full[3:0];
    assign is_num   = (text_char >= CH_ZERO) && (text_char <= CH_NINE);

    assign out_valid = (cnt_reg != 2'd0);
    assign in_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    assign event_kind         = slot0_reg.kind;
    assign frequency_hz       = slot0_reg.hz;
    assign length_denominator = slot0_reg.len;
    assign tempo_bpm          = slot0_reg.tempo;
    assign run_end            = slot0_reg.last;

    always_comb
    begin
        ps_t         s;
        ps_t         snap;
        logic        done;
        logic        emit_a;
        logic        have_note;
        logic [13:0] tmul;
        logic [7:0]  bmul;
        res_t        ev;
        res_t        ev_end;

        s         = st_reg;
        snap      = st_reg;
        cm_next   = cm_reg;
        done      = 1'b0;
        emit_a    = 1'b0;
        have_note = 1'b0;
        tmul      = ({4'd0, st_reg.tempo} * 14'd10) + {10'd0, dgt};
        bmul      = ({4'd0, st_reg.bo} * 8'd10) + {4'd0, dgt};

        if (s.pk != PK_NONE)
        begin
            if ((s.pk == PK_NOTE) && !s.fpos
                && ((text_char == CH_SHARP) || (text_char == CH_FLAT)))
            begin
                if (text_char == CH_SHARP)
                begin
                    if (s.key >= KEY_LAST)
                    begin
                        s.key = 4'd0;
                        if (s.oo != OFFSET_MAX)
                        begin
                            s.oo = s.oo + 4'sd1;
                        end
                    end
                    else
                    begin
                        s.key = s.key + 4'd1;
                    end
                end
                else
                begin
                    if (s.key == 4'd0)
                    begin
                        s.key = KEY_LAST;
                        if (s.oo != OFFSET_MIN)
                        begin
                            s.oo = s.oo - 4'sd1;
                        end
                    end
                    else
                    begin
                        s.key = s.key - 4'd1;
                    end
                end
                s.fpos = 1'b1;
                done   = 1'b1;
            end
            else if (is_num && (s.dc != 2'd2))
            begin
                if (s.dc == 2'd0)
                begin
                    s.fd = dgt;
                end
                else
                begin
                    s.sd = dgt;
                end
                s.dc   = s.dc + 2'd1;
                s.fpos = 1'b1;
                done   = 1'b1;
            end
            else
            begin
                if (text_char == CH_DOT)
                begin
                    s.dot = 1'b1;
                    done  = 1'b1;
                end
                snap   = s;
                emit_a = 1'b1;
                s.pk   = PK_NONE;
                s.oo   = 4'sd0;
            end
        end
        else if (cm_reg != CM_IDLE)
        begin
            unique case (cm_reg) inside
                CM_TEMPO:
                begin
                    if (is_num)
                    begin
                        s.tempo = (tmul > {4'd0, TEMPO_MAX}) ? TEMPO_MAX : tmul[9:0];
                        done    = 1'b1;
                    end
                end
                CM_OCT_FIRST, CM_OCT_MORE:
                begin
                    if (is_num)
                    begin
                        if (cm_reg == CM_OCT_FIRST)
                        begin
                            s.bo = dgt;
                        end
                        else
                        begin
                            s.bo = (bmul > {4'd0, OCTAVE_TOP}) ? OCTAVE_TOP : bmul[3:0];
                        end
                        cm_next = CM_OCT_MORE;
                        done    = 1'b1;
                    end
                end
                CM_LEN_FIRST:
                begin
                    if (is_num)
                    begin
                        s.fd    = dgt;
                        s.dl    = {3'd0, dgt};
                        cm_next = CM_LEN_SECOND;
                        done    = 1'b1;
                    end
                    else if (text_char == CH_DOT)
                    begin
                        s.dl    = div3({s.dl, 1'b0});
                        cm_next = CM_IDLE;
                        done    = 1'b1;
                    end
                end
                CM_LEN_SECOND:
                begin
                    if (is_num)
                    begin
                        s.dl    = two_digits(s.fd, dgt);
                        cm_next = CM_IDLE;
                        done    = 1'b1;
                    end
                    else if (text_char == CH_DOT)
                    begin
                        s.dl    = div3({3'd0, s.fd, 1'b0});
                        cm_next = CM_IDLE;
                        done    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            if (!done)
            begin
                cm_next = CM_IDLE;
            end
        end

        if (!done)
        begin
            unique case (text_char) inside
                CH_C, CH_D, CH_E, CH_F, CH_G, CH_A, CH_B, CH_REST:
                begin
                    s.pk   = (text_char == CH_REST) ? PK_REST : PK_NOTE;
                    s.fpos = (text_char == CH_REST);
                    s.fd   = 4'd0;
                    s.sd   = 4'd0;
                    s.dc   = 2'd0;
                    s.dot  = 1'b0;
                    unique case (text_char)
                        CH_D:    s.key = 4'd2;
                        CH_E:    s.key = 4'd4;
                        CH_F:    s.key = 4'd5;
                        CH_G:    s.key = 4'd7;
                        CH_A:    s.key = 4'd9;
                        CH_B:    s.key = 4'd11;
                        default: s.key = 4'd0;
                    endcase
                end
                CH_TEMPO:
                begin
                    s.tempo = 10'd0;
                    cm_next = CM_TEMPO;
                end
                CH_OCTAVE:
                begin
                    cm_next = CM_OCT_FIRST;
                end
                CH_LENGTH:
                begin
                    cm_next = CM_LEN_FIRST;
                end
                CH_UP:
                begin
                    if (s.bo != OCTAVE_TOP)
                    begin
                        s.bo = s.bo + 4'd1;
                    end
                end
                CH_DOWN:
                begin
                    if (s.bo != 4'd0)
                    begin
                        s.bo = s.bo - 4'd1;
                    end
                end
                CH_SHIFT_UP:
                begin
                    if (s.oo != OFFSET_MAX)
                    begin
                        s.oo = s.oo + 4'sd1;
                    end
                end
                CH_SHIFT_DOWN:
                begin
                    if (s.oo != OFFSET_MIN)
                    begin
                        s.oo = s.oo - 4'sd1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        have_note = emit_a;
        if (is_final)
        begin
            // A note started by the final character after a flushed note is dropped.
            if ((s.pk != PK_NONE) && !emit_a)
            begin
                snap      = s;
                have_note = 1'b1;
            end
            s.pk    = PK_NONE;
            s.oo    = 4'sd0;
            cm_next = CM_IDLE;
        end

        ev           = build_event(snap);
        ev_end.kind  = EV_END;
        ev_end.hz    = 12'd0;
        ev_end.len   = 7'd0;
        ev_end.tempo = s.tempo;
        ev_end.last  = 1'b1;

        r1 = ev_end;
        if (have_note)
        begin
            r0      = ev;
            r0.last = !is_final;
            k       = is_final ? 2'd2 : 2'd1;
        end
        else
        begin
            r0 = ev_end;
            k  = is_final ? 2'd1 : 2'd0;
        end

        st_next = s;
    end

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            slot0_next = r0;
            slot1_next = r1;
            cnt_next   = k;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= PS_RESET;
            cm_reg  <= CM_IDLE;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                st_reg <= st_next;
                cm_reg <= cm_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for mml_note_sequence_parser: MML characters in, note, rest and
// end events out, with an in-bench parser model and a scoreboard of expected events.
// Depends on mnsp_pkg and the parser RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mnsp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int KEY_TOP     = 11;
    localparam int OFF_TOP     = 7;
    localparam int OFF_BOTTOM  = -8;
    localparam int OCT_TOP     = 15;
    localparam int TEMPO_TOP   = 999;
    localparam int STALL_SPAN  = 300;

    localparam int TONE_TABLE [7][12] = '{
        '{33, 35, 37, 39, 41, 44, 46, 49, 52, 55, 58, 62},
        '{65, 69, 73, 78, 82, 87, 93, 98, 104, 110, 117, 123},
        '{131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247},
        '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494},
        '{523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988},
        '{1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976},
        '{2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951}
    };

    localparam logic [7:0] NOTE_LETTERS [7] = '{CH_C, CH_D, CH_E, CH_F, CH_G, CH_A, CH_B};
    localparam logic [7:0] SHIFT_CHARS [4]  = '{CH_UP, CH_DOWN, CH_SHIFT_UP, CH_SHIFT_DOWN};
    localparam logic [7:0] STRAY_CHARS [8]  = '{CH_SHARP, CH_FLAT, CH_DOT, CH_REST,
                                                CH_TEMPO, CH_OCTAVE, CH_LENGTH, CH_NINE};

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  text_char = 8'd0;
    logic        is_final = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_kind;
    logic [11:0] frequency_hz;
    logic [6:0]  length_denominator;
    logic [9:0]  tempo_bpm;
    logic        run_end;

    text_item_t  score_text [$];
    res_t        expected_events [$];
    text_item_t  next_item;
    res_t        wanted;
    res_t        step_events [2];
    int          step_count;
    int          text_pushed = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_gap_pct = 13;
    int          recv_gap_pct = 87;
    logic        hold_request = 1'b0;
    logic        hold_taken = 1'b0;
    int          hold_left = 0;

    // Parser model state.
    logic [1:0]  note_kind = PK_NONE;
    int          note_key = 0;
    logic        accidental_closed = 1'b0;
    int          digit_hi = 0;
    int          digit_lo = 0;
    int          digits_taken = 0;
    logic        dotted = 1'b0;
    int          base_oct = 4;
    int          oct_shift = 0;
    int          default_len = 4;
    int          tempo_now = 120;
    cmd_t        command = CM_IDLE;

    mml_note_sequence_parser uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .text_char          (text_char),
        .is_final           (is_final),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .event_kind         (event_kind),
        .frequency_hz       (frequency_hz),
        .length_denominator (length_denominator),
        .tempo_bpm          (tempo_bpm),
        .run_end            (run_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic char_is_numeral(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    task automatic push_event(input logic [1:0] kind, input int hz, input int len);
        res_t r;
        begin
            r.kind  = kind;
            r.hz    = 12'(hz);
            r.len   = 7'(len);
            r.tempo = 10'(tempo_now);
            r.last  = 1'b0;
            step_events[step_count] = r;
            step_count++;
        end
    endtask

    task automatic flush_note();
        int len;
        int oct;
        begin
            len = (digits_taken == 0) ? default_len
                : (digits_taken == 1) ? digit_hi : digit_hi * 10 + digit_lo;
            if (dotted)
            begin
                len = (2 * len) / 3;
            end
            if (note_kind == PK_NOTE)
            begin
                oct = base_oct + oct_shift;
                if (oct < 1)
                begin
                    oct = 1;
                end
                if (oct > OCTAVE_ROWS)
                begin
                    oct = OCTAVE_ROWS;
                end
                if (oct > 7)
                begin
                    oct = 7;
                end
                push_event(EV_NOTE, TONE_TABLE[oct - 1][note_key], len);
            end
            else
            begin
                push_event(EV_REST, 0, len);
            end
            note_kind = PK_NONE;
            oct_shift = 0;
        end
    endtask

    task automatic open_note(input logic [1:0] kind, input int key);
        begin
            note_kind         = kind;
            note_key          = key;
            accidental_closed = (kind != PK_NOTE);
            digit_hi          = 0;
            digit_lo          = 0;
            digits_taken      = 0;
            dotted            = 1'b0;
        end
    endtask

    task automatic interpret_char(input logic [7:0] ch, input logic fin);
        logic taken;
        int   d;
        begin
            taken = 1'b0;
            step_count = 0;
            d = int'(ch) - int'(CH_ZERO);
            if (note_kind != PK_NONE)
            begin
                if (note_kind == PK_NOTE && !accidental_closed
                    && (ch == CH_SHARP || ch == CH_FLAT))
                begin
                    if (ch == CH_SHARP)
                    begin
                        if (note_key >= KEY_TOP)
                        begin
                            note_key = 0;
                            if (oct_shift < OFF_TOP)
                            begin
                                oct_shift++;
                            end
                        end
                        else
                        begin
                            note_key++;
                        end
                    end
                    else if (note_key == 0)
                    begin
                        note_key = KEY_TOP;
                        if (oct_shift > OFF_BOTTOM)
                        begin
                            oct_shift--;
                        end
                    end
                    else
                    begin
                        note_key--;
                    end
                    accidental_closed = 1'b1;
                    taken = 1'b1;
                end
                else if (char_is_numeral(ch) && digits_taken < 2)
                begin
                    if (digits_taken == 0)
                    begin
                        digit_hi = d;
                    end
                    else
                    begin
                        digit_lo = d;
                    end
                    digits_taken++;
                    accidental_closed = 1'b1;
                    taken = 1'b1;
                end
                else if (ch == CH_DOT)
                begin
                    dotted = 1'b1;
                    flush_note();
                    taken = 1'b1;
                end
                if (!taken)
                begin
                    flush_note();
                end
            end
            else if (command != CM_IDLE)
            begin
                case (command) inside
                    CM_TEMPO:
                    begin
                        if (char_is_numeral(ch))
                        begin
                            tempo_now = tempo_now * 10 + d;
                            if (tempo_now > TEMPO_TOP)
                            begin
                                tempo_now = TEMPO_TOP;
                            end
                            taken = 1'b1;
                        end
                    end
                    CM_OCT_FIRST, CM_OCT_MORE:
                    begin
                        if (char_is_numeral(ch))
                        begin
                            base_oct = (command == CM_OCT_FIRST) ? d : base_oct * 10 + d;
                            if (base_oct > OCT_TOP)
                            begin
                                base_oct = OCT_TOP;
                            end
                            command = CM_OCT_MORE;
                            taken = 1'b1;
                        end
                    end
                    CM_LEN_FIRST:
                    begin
                        if (char_is_numeral(ch))
                        begin
                            digit_hi = d;
                            default_len = d;
                            command = CM_LEN_SECOND;
                            taken = 1'b1;
                        end
                        else if (ch == CH_DOT)
                        begin
                            default_len = (2 * default_len) / 3;
                            command = CM_IDLE;
                            taken = 1'b1;
                        end
                    end
                    CM_LEN_SECOND:
                    begin
                        if (char_is_numeral(ch))
                        begin
                            default_len = digit_hi * 10 + d;
                            command = CM_IDLE;
                            taken = 1'b1;
                        end
                        else if (ch == CH_DOT)
                        begin
                            default_len = (2 * digit_hi) / 3;
                            command = CM_IDLE;
                            taken = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (!taken)
                begin
                    command = CM_IDLE;
                end
            end
            if (!taken)
            begin
                case (ch)
                    CH_C:      open_note(PK_NOTE, 0);
                    CH_D:      open_note(PK_NOTE, 2);
                    CH_E:      open_note(PK_NOTE, 4);
                    CH_F:      open_note(PK_NOTE, 5);
                    CH_G:      open_note(PK_NOTE, 7);
                    CH_A:      open_note(PK_NOTE, 9);
                    CH_B:      open_note(PK_NOTE, 11);
                    CH_REST:   open_note(PK_REST, 0);
                    CH_TEMPO:
                    begin
                        tempo_now = 0;
                        command = CM_TEMPO;
                    end
                    CH_OCTAVE: command = CM_OCT_FIRST;
                    CH_LENGTH: command = CM_LEN_FIRST;
                    CH_UP:         if (base_oct < OCT_TOP) base_oct++;
                    CH_DOWN:       if (base_oct > 0) base_oct--;
                    CH_SHIFT_UP:   if (oct_shift < OFF_TOP) oct_shift++;
                    CH_SHIFT_DOWN: if (oct_shift > OFF_BOTTOM) oct_shift--;
                    default:
                    begin
                    end
                endcase
            end
            if (fin)
            begin
                if (note_kind != PK_NONE)
                begin
                    if (step_count == 0)
                    begin
                        flush_note();
                    end
                    else
                    begin
                        note_kind = PK_NONE;
                    end
                end
                push_event(EV_END, 0, 0);
                note_kind = PK_NONE;
                command = CM_IDLE;
                oct_shift = 0;
            end
            if (step_count > 0)
            begin
                step_events[step_count - 1].last = 1'b1;
            end
            for (int i = 0; i < step_count; i++)
            begin
                expected_events.push_back(step_events[i]);
            end
        end
    endtask

    task automatic add_char(input logic [7:0] ch, input logic fin);
        text_item_t item;
        begin
            item.ch  = ch;
            item.fin = fin;
            score_text.push_back(item);
            text_pushed++;
        end
    endtask

    task automatic add_text(input string s, input logic fin_last);
        begin
            for (int i = 0; i < s.len(); i++)
            begin
                add_char(8'(s[i]), fin_last && (i == s.len() - 1));
            end
        end
    endtask

    function automatic logic roll_final();
        return $urandom_range(0, 39) == 0;
    endfunction

    task automatic add_digits(input int count);
        begin
            for (int i = 0; i < count; i++)
            begin
                add_char(8'(CH_ZERO + $urandom_range(0, 9)), roll_final());
            end
        end
    endtask

    task automatic queue_random(input int item_count);
        int         target;
        int         choice;
        int         run_len;
        logic [7:0] run_char;
        begin
            target = text_pushed + item_count;
            while (text_pushed < target)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 45)
                begin
                    add_char(NOTE_LETTERS[$urandom_range(0, 6)], roll_final());
                    if ($urandom_range(0, 9) < 4)
                    begin
                        add_char($urandom_range(0, 1) ? CH_SHARP : CH_FLAT, roll_final());
                    end
                    add_digits($urandom_range(0, 2));
                    if ($urandom_range(0, 3) == 0)
                    begin
                        add_char(CH_DOT, roll_final());
                    end
                end
                else if (choice < 55)
                begin
                    add_char(CH_REST, roll_final());
                    add_digits($urandom_range(0, 2));
                    if ($urandom_range(0, 4) == 0)
                    begin
                        add_char(CH_DOT, roll_final());
                    end
                end
                else if (choice < 62)
                begin
                    add_char(CH_TEMPO, roll_final());
                    add_digits($urandom_range(0, 4));
                end
                else if (choice < 68)
                begin
                    add_char(CH_OCTAVE, roll_final());
                    add_digits($urandom_range(0, 2));
                end
                else if (choice < 76)
                begin
                    add_char(CH_LENGTH, roll_final());
                    add_digits($urandom_range(0, 2));
                    if ($urandom_range(0, 2) == 0)
                    begin
                        add_char(CH_DOT, roll_final());
                    end
                end
                else if (choice < 88)
                begin
                    run_len  = $urandom_range(1, 10);
                    run_char = SHIFT_CHARS[$urandom_range(0, 3)];
                    for (int i = 0; i < run_len; i++)
                    begin
                        add_char(run_char, roll_final());
                    end
                end
                else if (choice < 96)
                begin
                    add_char(8'($urandom_range(0, 255)), roll_final());
                end
                else
                begin
                    add_char(STRAY_CHARS[$urandom_range(0, 7)], roll_final());
                end
            end
        end
    endtask

    task automatic wait_for_drain();
        begin
            while (score_text.size() != 0 || in_valid || expected_events.size() != 0)
            begin
                @(negedge clk);
            end
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        begin
            if (want != got)
            begin
                $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
                error_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                interpret_char(text_char, is_final);
            end
            if (!in_valid || in_ready)
            begin
                if (score_text.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    next_item = score_text.pop_front();
                    in_valid  <= 1'b1;
                    text_char <= next_item.ch;
                    is_final  <= next_item.fin;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_left  <= STALL_SPAN;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected event, expected none, actual kind %0d hz %0d len %0d",
                             $time, event_kind, frequency_hz, length_denominator);
                    error_count++;
                end
                else
                begin
                    wanted = expected_events.pop_front();
                    check_field("event_kind", wanted.kind, event_kind);
                    check_field("frequency_hz", wanted.hz, frequency_hz);
                    check_field("length_denominator", wanted.len, length_denominator);
                    check_field("tempo_bpm", wanted.tempo, tempo_bpm);
                    check_field("run_end", wanted.last, run_end);
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        // Tempo and octave saturation, sharp wrap with a dotted two-digit length,
        // dotted default length, flat wrap below the lowest row, a rest flushed by
        // the final character, and a final note letter dropped behind a pending note.
        add_text("t9999", 1'b0);
        add_text("o99", 1'b0);
        add_text("b+99.", 1'b0);
        add_text("l5.", 1'b0);
        add_text("o0_c-", 1'b0);
        add_text("r7", 1'b1);
        add_text("cd", 1'b1);
        add_char(8'hFF, 1'b0);
        add_char(8'h00, 1'b1);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        queue_random(600);
        wait_for_drain();

        send_gap_pct = 87;
        recv_gap_pct = 13;
        queue_random(550);
        wait_for_drain();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        queue_random(550);
        hold_request = 1'b1;
        wait_for_drain();

        repeat (20) @(negedge clk);
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
